### sv/bfsa_pkg.sv
// Shared types and constants for the best-fit segment allocator.
// Used by best_fit_segment_allocator_top; depends on nothing.
package bfsa_pkg;

	typedef enum logic [2:0] {
		CMD_ALLOC     = 3'd0,
		CMD_FREE      = 3'd1,
		CMD_TRANSFER  = 3'd2,
		CMD_KEEP      = 3'd3,
		CMD_FREE_TASK = 3'd4,
		CMD_FIND      = 3'd5,
		CMD_INIT      = 3'd6
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_COPY,
		S_AL_W1,
		S_AL_W2,
		S_REL0,
		S_REL1,
		S_REL2,
		S_FT_RD,
		S_FT_CHK,
		S_FT_NEXT,
		S_DONE
	} state_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [1:0] CFG_POOL_BASE    = 2'd0;
	localparam logic [1:0] CFG_POOL_BYTES   = 2'd1;
	localparam logic [1:0] CFG_MULTITASKING = 2'd2;

	localparam logic [7:0]  OWNER_NONE     = 8'hFF;
	localparam logic [31:0] POOL_BYTES_RST = 32'd400000;

endpackage

### sv/best_fit_segment_allocator_top.sv
// Best-fit segment allocator: block table in one synchronous RAM, walked by a sequencer.
// Depends on bfsa_pkg.
//
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata: command, address, length, current_task,
//         |     |                    |          want_owner, target_task, keep_flag
// m_*     | out | m_tvalid/m_tready  | m_tdata: status, block_base, entry_index
// cfg_*   | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One command at a time. Lookups do one RAM read per cycle; free task reads every entry.
// Alloc shifts entries above a split block up, then writes the remainder and new block;
// free merges free neighbours and shifts entries above down; free task releases each match.
// Entry 0 reads as the reset pool until first written; no clearing pass.
// A finished result waits in the output register while the next command is taken.
module best_fit_segment_allocator_top
	import bfsa_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int ADDRESS_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[2:0], address[34:3], length[66:35], current_task[73:67],
	// want_owner[74], target_task[82:75], keep_flag[83], zero[87:84]
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], block_base[33:2], entry_index[39:34]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef logic [ADDRESS_BITS-1:0] aw_t;
	typedef logic [IW-1:0] idx_t;
	typedef logic [CW-1:0] cnt_t;

	typedef struct packed {
		aw_t         base;
		logic [31:0] len;
		logic [7:0]  owner;
		logic        kept;
		logic        free;
	} entry_t;

	localparam cnt_t COUNT_MAX = cnt_t'(TABLE_ENTRIES);

	// configuration
	logic [31:0] pool_base_q, pool_bytes_q;
	logic        multi_q;

	// command
	logic [2:0]  cmd_q;
	aw_t         addr_q;
	logic [31:0] len_q;
	logic [6:0]  task_q;
	logic        want_q;
	logic [7:0]  tt_q;
	logic        keep_q;

	state_t state_q, state_d, ret_q, rel_ret_q;
	cnt_t   count_q, idx_q;
	logic   e0v_q, rv_q, found_q;
	idx_t   best_q, pos_q, k_q, rd_idx_s1;
	entry_t best_e_q, cur_e_q, low_e_q;

	cnt_t   cp_n_q, cp_src_q, cp_dst_q;
	logic   cp_up_q, cp_v_q;
	idx_t   cp_dst_s1;

	logic [1:0]  res_status_q;
	logic [31:0] res_base_q;
	logic [5:0]  res_idx_q;
	logic        out_v_q;
	logic [39:0] out_q;

	entry_t mem [TABLE_ENTRIES];
	entry_t mem_q, rd_e;

	idx_t   rd_addr;
	logic   wr_en;
	idx_t   wr_addr;
	entry_t wr_data;
	logic   scan_issue, cp_issue, hit, scan_end, accept;

	entry_t e0_rst, new_e, split_e, merged_e;
	logic   owned, scan_find, lf, uf;
	idx_t   rel_s;
	cnt_t   rel_r;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_q;

	always_comb begin
		e0_rst = '{base: '0, len: POOL_BYTES_RST, owner: OWNER_NONE, kept: 1'b1, free: 1'b1};
		rd_e   = (rd_idx_s1 == '0 && !e0v_q) ? e0_rst : mem_q;
		owned  = multi_q && want_q;
		new_e  = '{base: best_e_q.base, len: len_q,
			owner: owned ? {1'b0, task_q} : OWNER_NONE, kept: !owned, free: 1'b0};
		split_e = '{base: best_e_q.base + aw_t'(len_q), len: best_e_q.len - len_q,
			owner: best_e_q.owner, kept: best_e_q.kept, free: best_e_q.free};
		lf = (pos_q != '0) && low_e_q.free;
		uf = ((cnt_t'(pos_q) + cnt_t'(1)) < count_q) && rd_e.free;
		rel_s = lf ? pos_q - idx_t'(1) : pos_q;
		rel_r = cnt_t'(lf) + cnt_t'(uf);
		merged_e.base  = lf ? low_e_q.base : cur_e_q.base;
		merged_e.len   = cur_e_q.len + (lf ? low_e_q.len : 32'd0) + (uf ? rd_e.len : 32'd0);
		merged_e.owner = uf ? rd_e.owner : OWNER_NONE;
		merged_e.kept  = uf ? rd_e.kept : 1'b0;
		merged_e.free  = 1'b1;
		scan_find = (cmd_q != CMD_ALLOC);
		if (scan_find)
			hit = rv_q && !found_q && (rd_e.base == addr_q);
		else
			hit = rv_q && rd_e.free && (rd_e.len >= len_q) &&
				(!found_q || rd_e.len < best_e_q.len);
		scan_issue = (state_q == S_SCAN) && (idx_q < count_q) && !(scan_find && found_q);
		scan_end   = (idx_q == count_q && !rv_q) || (scan_find && found_q);
		cp_issue   = (state_q == S_COPY) && (cp_n_q != '0);
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = best_q;
		wr_data = new_e;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tdata[2:0])
						CMD_ALLOC:     state_d = (s_tdata[66:35] == '0) ? S_DONE : S_SCAN;
						CMD_FREE,
						CMD_TRANSFER,
						CMD_KEEP,
						CMD_FIND:      state_d = S_SCAN;
						CMD_FREE_TASK: state_d = S_FT_RD;
						CMD_INIT: begin
							wr_en   = 1'b1;
							wr_addr = '0;
							wr_data = '{base: aw_t'(pool_base_q), len: pool_bytes_q,
								owner: OWNER_NONE, kept: 1'b1, free: 1'b1};
							state_d = S_DONE;
						end
						default:       state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DONE;
					if (found_q) begin
						case (cmd_q)
							CMD_ALLOC: begin
								if (count_q < COUNT_MAX) begin
									if (best_e_q.len == len_q)
										wr_en = 1'b1;
									else
										state_d = S_COPY;
								end
							end
							CMD_TRANSFER: begin
								wr_en   = 1'b1;
								wr_data = best_e_q;
								wr_data.owner = tt_q;
							end
							CMD_KEEP: begin
								wr_en   = 1'b1;
								wr_data = best_e_q;
								wr_data.kept = keep_q;
							end
							CMD_FREE: begin
								if (!best_e_q.free)
									state_d = S_REL0;
							end
							default: ;
						endcase
					end
				end
			end
			S_COPY: begin
				rd_addr = cp_src_q[IW-1:0];
				wr_en   = cp_v_q;
				wr_addr = cp_dst_s1;
				wr_data = rd_e;
				if (cp_n_q == '0 && !cp_v_q)
					state_d = ret_q;
			end
			S_AL_W1: begin
				wr_en   = 1'b1;
				wr_addr = best_q + idx_t'(1);
				wr_data = split_e;
				state_d = S_AL_W2;
			end
			S_AL_W2: begin
				wr_en   = 1'b1;
				state_d = S_DONE;
			end
			S_REL0: begin
				rd_addr = pos_q - idx_t'(1);
				state_d = S_REL1;
			end
			S_REL1: begin
				rd_addr = pos_q + idx_t'(1);
				state_d = S_REL2;
			end
			S_REL2: begin
				wr_en   = 1'b1;
				wr_addr = rel_s;
				wr_data = merged_e;
				state_d = S_COPY;
			end
			S_FT_RD: begin
				rd_addr = k_q;
				state_d = S_FT_CHK;
			end
			S_FT_CHK: begin
				if (rd_e.owner == tt_q && !rd_e.kept && !rd_e.free)
					state_d = S_REL0;
				else
					state_d = S_FT_NEXT;
			end
			S_FT_NEXT: begin
				if (k_q == '0)
					state_d = S_DONE;
				else if (cnt_t'(k_q - idx_t'(1)) < count_q)
					state_d = S_FT_RD;
			end
			S_DONE: begin
				if (!out_v_q || m_tready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		mem_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_bytes_q <= POOL_BYTES_RST;
			multi_q      <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_POOL_BASE:    pool_base_q  <= cfg_data;
				CFG_POOL_BYTES:   pool_bytes_q <= cfg_data;
				CFG_MULTITASKING: multi_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= cnt_t'(1);
			e0v_q     <= 1'b0;
			rv_q      <= 1'b0;
			cp_v_q    <= 1'b0;
			out_v_q   <= 1'b0;
			found_q   <= 1'b0;
			idx_q     <= '0;
			rd_idx_s1 <= '0;
		end else begin
			rd_idx_s1 <= rd_addr;
			rv_q      <= scan_issue;
			cp_v_q    <= cp_issue;
			if (wr_en && wr_addr == '0)
				e0v_q <= 1'b1;
			if (scan_issue)
				idx_q <= idx_q + cnt_t'(1);
			if (hit) begin
				found_q  <= 1'b1;
				best_q   <= rd_idx_s1;
				best_e_q <= rd_e;
			end
			if (cp_issue) begin
				cp_n_q    <= cp_n_q - cnt_t'(1);
				cp_src_q  <= cp_up_q ? cp_src_q + cnt_t'(1) : cp_src_q - cnt_t'(1);
				cp_dst_q  <= cp_up_q ? cp_dst_q + cnt_t'(1) : cp_dst_q - cnt_t'(1);
				cp_dst_s1 <= cp_dst_q[IW-1:0];
			end
			if (m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= s_tdata[2:0];
						addr_q       <= aw_t'(s_tdata[34:3]);
						len_q        <= s_tdata[66:35];
						task_q       <= s_tdata[73:67];
						want_q       <= s_tdata[74];
						tt_q         <= s_tdata[82:75];
						keep_q       <= s_tdata[83];
						res_status_q <= ST_MISS;
						res_base_q   <= '0;
						res_idx_q    <= '0;
						idx_q        <= '0;
						found_q      <= 1'b0;
						k_q          <= idx_t'(count_q - cnt_t'(1));
						if (s_tdata[2:0] == CMD_INIT) begin
							count_q      <= cnt_t'(1);
							res_status_q <= ST_OK;
						end
					end
				end
				S_SCAN: begin
					if (scan_end && found_q) begin
						res_status_q <= ST_OK;
						case (cmd_q)
							CMD_ALLOC: begin
								if (count_q >= COUNT_MAX)
									res_status_q <= ST_FULL;
								else
									res_base_q <= 32'(best_e_q.base);
								cp_n_q   <= count_q - cnt_t'(best_q) - cnt_t'(1);
								cp_src_q <= count_q - cnt_t'(1);
								cp_dst_q <= count_q;
								cp_up_q  <= 1'b0;
								ret_q    <= S_AL_W1;
							end
							CMD_FIND: res_idx_q <= 6'(best_q);
							CMD_FREE: begin
								pos_q     <= best_q;
								cur_e_q   <= best_e_q;
								rel_ret_q <= S_DONE;
							end
							default: ;
						endcase
					end
				end
				S_AL_W2: count_q <= count_q + cnt_t'(1);
				S_REL1:  low_e_q <= rd_e;
				S_REL2: begin
					count_q  <= count_q - rel_r;
					cp_n_q   <= count_q - rel_r - cnt_t'(rel_s) - cnt_t'(1);
					cp_src_q <= cnt_t'(rel_s) + cnt_t'(1) + rel_r;
					cp_dst_q <= cnt_t'(rel_s) + cnt_t'(1);
					cp_up_q  <= 1'b1;
					ret_q    <= rel_ret_q;
				end
				S_FT_CHK: begin
					pos_q     <= k_q;
					cur_e_q   <= rd_e;
					rel_ret_q <= S_FT_NEXT;
				end
				S_FT_NEXT: begin
					if (k_q == '0)
						res_status_q <= ST_OK;
					else
						k_q <= k_q - idx_t'(1);
				end
				S_DONE: begin
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						out_q   <= {res_idx_q, res_base_q, res_status_q};
					end
				end
				default: ;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= COUNT_MAX)
		else $error("entry count out of range");

	a_copy_state: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_q |-> state_q == S_COPY)
		else $error("copy write outside copy phase");

	a_alloc_grow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_AL_W2 |=> count_q == $past(count_q) + cnt_t'(1))
		else $error("split alloc did not grow table");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cp_v_q && !rv_q)
		else $error("table access pending while idle");

endmodule
